>>> src/operator_admission_table_defines.svh
// Assertion helpers used by the admission table RTL.
`ifndef OPERATOR_ADMISSION_TABLE_DEFINES_SVH
`define OPERATOR_ADMISSION_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OAT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OAT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/oat_pkg.sv
package oat_pkg;

   localparam int TABLE_SLOTS  = 16;
   localparam int SLOT_IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int SERVERS      = 64;
   localparam int SERVER_ID_W  = 6;
   localparam int MAX_AFFECTED = 4;
   localparam int FIELD_COUNT  = 4;
   localparam int AFFECTED     = (MAX_AFFECTED < FIELD_COUNT) ? MAX_AFFECTED : FIELD_COUNT;
   localparam int COUNT_W      = 3;
   localparam int HITS_W       = 3;
   localparam int LOAD_W       = 8;
   localparam int LIMIT_W      = 8;
   localparam int POOL_W       = 16;
   localparam int GROUP_W      = 32;
   localparam int PRIO_W       = 2;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_BUSY   = 2'd2,
      REQ_LOOKUP = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_OVER_LIMIT  = 3'd1,
      ST_NOT_HIGHER  = 3'd2,
      ST_TABLE_FULL  = 3'd3,
      ST_NOT_FOUND   = 3'd4
   } status_type;

   typedef logic [SERVER_ID_W-1:0] server_id_type;

   // Request from the table logic to the per-server load counters.
   typedef struct packed {
      server_id_type [AFFECTED-1:0] new_srv;
      logic [AFFECTED-1:0]          new_en;
      server_id_type [AFFECTED-1:0] old_srv;
      logic [AFFECTED-1:0]          old_en;
      server_id_type                query_srv;
      logic                         commit;
   } lane_req_type;

   typedef struct packed {
      logic fits;
      logic busy;
   } lane_rsp_type;

endpackage

>>> src/operator_admission_table.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | req_type, key, priority, server list
// rsp     | out       | rsp_valid/rsp_ready  | status, busy answer, looked-up entry
// csr     | in        | csr_valid/csr_ready  | csr_concurrency_limit
//
// One item per cycle sustained while rsp is not stalled; an accepted item
// passes the input register, then the result register. The work is one pass
// through key match and the 64 load counter lanes between the two registers.
// Reset clears the slot valid bits, every server load and sets the limit to 1;
// no clearing pass. A stalled rsp holds the result and the input register,
// and req_ready drops until the result is taken.
`include "operator_admission_table_defines.svh"

module operator_admission_table (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_pool_id,
   input  logic [31:0] req_group_id,
   input  logic [1:0]  req_job_priority,
   input  logic [2:0]  req_server_count,
   input  logic [5:0]  req_server_a,
   input  logic [5:0]  req_server_b,
   input  logic [5:0]  req_server_c,
   input  logic [5:0]  req_server_d,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_server_busy,
   output logic [1:0]  rsp_found_priority,
   output logic [2:0]  rsp_found_count,
   output logic [5:0]  rsp_found_server_a,
   output logic [5:0]  rsp_found_server_b,
   output logic [5:0]  rsp_found_server_c,
   output logic [5:0]  rsp_found_server_d,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_concurrency_limit
);
   import oat_pkg::*;

   // ---------------- configuration ----------------
   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_concurrency_limit : limit_ff;

   // ---------------- input register ----------------
   logic                               in_valid_ff;
   logic                               in_valid_in;
   req_kind_type                       in_kind_ff;
   logic [POOL_W-1:0]                  in_pool_ff;
   logic [GROUP_W-1:0]                 in_group_ff;
   logic [PRIO_W-1:0]                  in_prio_ff;
   logic [COUNT_W-1:0]                 in_count_ff;
   server_id_type [FIELD_COUNT-1:0]    in_srv_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   status_type                   rsp_status_ff;
   logic                         rsp_busy_ff;
   logic [PRIO_W-1:0]            rsp_prio_ff;
   logic [COUNT_W-1:0]           rsp_count_ff;
   server_id_type [AFFECTED-1:0] rsp_srv_ff;

   logic advance;
   logic accept;

   // Advance the held item when the result register is empty or being taken.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // ---------------- job table ----------------
   logic [TABLE_SLOTS-1:0]         slot_valid_ff;
   logic [POOL_W-1:0]              slot_pool_ff  [TABLE_SLOTS];
   logic [GROUP_W-1:0]             slot_group_ff [TABLE_SLOTS];
   logic [PRIO_W-1:0]              slot_prio_ff  [TABLE_SLOTS];
   logic [COUNT_W-1:0]             slot_count_ff [TABLE_SLOTS];
   server_id_type [AFFECTED-1:0]   slot_srv_ff   [TABLE_SLOTS];

   logic [TABLE_SLOTS-1:0] match_vec;
   logic                   hit;
   logic [SLOT_IDX_W-1:0]  hit_idx;
   logic                   free_any;
   logic [SLOT_IDX_W-1:0]  free_idx;

   // Keys are unique, but take the lowest match anyway; lowest free slot wins.
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         match_vec[i] = slot_valid_ff[i] && (slot_pool_ff[i] == in_pool_ff)
                        && (slot_group_ff[i] == in_group_ff);
      end
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            hit     = 1'b1;
            hit_idx = SLOT_IDX_W'(i);
         end
         if (!slot_valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_IDX_W'(i);
         end
      end
   end

   logic [PRIO_W-1:0]            rd_prio;
   logic [COUNT_W-1:0]           rd_count;
   server_id_type [AFFECTED-1:0] rd_srv;

   assign rd_prio  = slot_prio_ff[hit_idx];
   assign rd_count = slot_count_ff[hit_idx];
   assign rd_srv   = slot_srv_ff[hit_idx];

   // ---------------- server lists ----------------
   logic [COUNT_W-1:0]           new_n;
   logic [COUNT_W-1:0]           old_n;
   logic [AFFECTED-1:0]          new_mask;
   logic [AFFECTED-1:0]          old_mask;
   server_id_type [AFFECTED-1:0] new_list;
   server_id_type [AFFECTED-1:0] store_list;

   // Clamp the counts to the list length; servers past the count store as 0.
   always_comb begin
      new_n = (in_count_ff > COUNT_W'(AFFECTED)) ? COUNT_W'(AFFECTED) : in_count_ff;
      old_n = (rd_count > COUNT_W'(AFFECTED)) ? COUNT_W'(AFFECTED) : rd_count;
      for (int i = 0; i < AFFECTED; i++) begin
         new_mask[i]   = COUNT_W'(i) < new_n;
         old_mask[i]   = COUNT_W'(i) < old_n;
         new_list[i]   = in_srv_ff[i];
         store_list[i] = new_mask[i] ? in_srv_ff[i] : '0;
      end
   end

   // ---------------- decision ----------------
   lane_req_type             lane_req;
   lane_rsp_type             lane_rsp;
   logic                     want_commit;
   logic                     wr_en;
   logic                     clr_en;
   logic [SLOT_IDX_W-1:0]    wr_idx;
   status_type               status_in;
   logic                     busy_in;
   logic [PRIO_W-1:0]        found_prio_in;
   logic [COUNT_W-1:0]       found_count_in;
   server_id_type [AFFECTED-1:0] found_srv_in;

   always_comb begin
      lane_req.new_srv   = new_list;
      lane_req.new_en    = '0;
      lane_req.old_srv   = rd_srv;
      lane_req.old_en    = '0;
      lane_req.query_srv = in_srv_ff[0];
      want_commit        = 1'b0;
      wr_en              = 1'b0;
      clr_en             = 1'b0;
      wr_idx             = hit_idx;
      status_in          = ST_OK;
      busy_in            = 1'b0;
      found_prio_in      = '0;
      found_count_in     = '0;
      found_srv_in       = '0;
      case (in_kind_ff)
         REQ_ADD: begin
            lane_req.new_en = new_mask;
            if (!hit) begin
               // New key: limit check comes before the table full check.
               if (!lane_rsp.fits) begin
                  status_in = ST_OVER_LIMIT;
               end else if (!free_any) begin
                  status_in = ST_TABLE_FULL;
               end else begin
                  want_commit = 1'b1;
                  wr_en       = 1'b1;
                  wr_idx      = free_idx;
               end
            end else if (!(rd_prio < in_prio_ff)) begin
               status_in = ST_NOT_HIGHER;
            end else begin
               // Replacement: lanes weigh the net change, old list against new.
               lane_req.old_en = old_mask;
               if (!lane_rsp.fits) begin
                  status_in = ST_OVER_LIMIT;
               end else begin
                  want_commit = 1'b1;
                  wr_en       = 1'b1;
               end
            end
         end
         REQ_REMOVE: begin
            if (!hit) begin
               status_in = ST_NOT_FOUND;
            end else begin
               lane_req.old_en = old_mask;
               want_commit     = 1'b1;
               clr_en          = 1'b1;
            end
         end
         REQ_BUSY: begin
            busy_in = lane_rsp.busy;
         end
         REQ_LOOKUP: begin
            if (!hit) begin
               status_in = ST_NOT_FOUND;
            end else begin
               found_prio_in  = rd_prio;
               found_count_in = rd_count;
               found_srv_in   = rd_srv;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
      lane_req.commit = advance && want_commit;
   end

   oat_load_lanes u_lanes (
      .clock    (clock),
      .reset    (reset),
      .limit    (limit_ff),
      .lane_req (lane_req),
      .lane_rsp (lane_rsp)
   );

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
      end else begin
         limit_ff     <= limit_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && wr_en) begin
            slot_valid_ff[wr_idx] <= 1'b1;
         end else if (advance && clr_en) begin
            slot_valid_ff[hit_idx] <= 1'b0;
         end
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff  <= req_kind_type'(req_type);
         in_pool_ff  <= req_pool_id;
         in_group_ff <= req_group_id;
         in_prio_ff  <= req_job_priority;
         in_count_ff <= req_server_count;
         in_srv_ff   <= {req_server_d, req_server_c, req_server_b, req_server_a};
      end
      if (advance && wr_en) begin
         slot_pool_ff[wr_idx]  <= in_pool_ff;
         slot_group_ff[wr_idx] <= in_group_ff;
         slot_prio_ff[wr_idx]  <= in_prio_ff;
         slot_count_ff[wr_idx] <= new_n;
         slot_srv_ff[wr_idx]   <= store_list;
      end
      if (advance) begin
         rsp_status_ff <= status_in;
         rsp_busy_ff   <= busy_in;
         rsp_prio_ff   <= found_prio_in;
         rsp_count_ff  <= found_count_in;
         rsp_srv_ff    <= found_srv_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_server_busy    = rsp_busy_ff;
   assign rsp_found_priority = rsp_prio_ff;
   assign rsp_found_count    = rsp_count_ff;
   assign rsp_found_server_a = rsp_srv_ff[0];
   assign rsp_found_server_b = rsp_srv_ff[1];
   assign rsp_found_server_c = rsp_srv_ff[2];
   assign rsp_found_server_d = rsp_srv_ff[3];

   // ---------------- assertions ----------------
   `OAT_ASSERT_IMP(a_full_only_when_all_valid, clock, reset, advance && (status_in == ST_TABLE_FULL), &slot_valid_ff, "table full reported with a free slot")
   `OAT_ASSERT_NEXT(a_remove_frees_slot, clock, reset, lane_req.commit && clr_en, !slot_valid_ff[$past(hit_idx)], "removed slot still valid")
   `OAT_ASSERT_IMP(a_add_commit_fits, clock, reset, lane_req.commit && (in_kind_ff == REQ_ADD), lane_rsp.fits, "add committed over the limit")
   `OAT_ASSERT_IMP(a_unique_key, clock, reset, in_valid_ff, $onehot0(match_vec), "key matches more than one slot")
   `OAT_ASSERT_NEXT(a_advance_gives_result, clock, reset, advance, rsp_valid_ff, "advanced item left no result")

endmodule

>>> src/oat_load_lanes.sv
module oat_load_lanes (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [oat_pkg::LIMIT_W-1:0]  limit,
   input  oat_pkg::lane_req_type        lane_req,
   output oat_pkg::lane_rsp_type        lane_rsp
);
   import oat_pkg::*;

   logic [SERVERS-1:0] violate;
   logic [SERVERS-1:0] busy_vec;

   // One counter lane per server: count its hits in both lists, check, update.
   for (genvar s = 0; s < SERVERS; s++) begin : g_lane
      logic [LOAD_W-1:0] load_ff;
      logic [LOAD_W-1:0] load_in;
      logic [HITS_W-1:0] new_hits;
      logic [HITS_W-1:0] old_hits;
      logic [LOAD_W+1:0] up_sum;
      logic [LOAD_W+1:0] bound;
      logic [LOAD_W-1:0] dec_load;
      logic [LOAD_W:0]   inc_sum;
      logic              lane_violate;

      always_comb begin
         new_hits = '0;
         old_hits = '0;
         for (int i = 0; i < AFFECTED; i++) begin
            if (lane_req.new_en[i] && (lane_req.new_srv[i] == SERVER_ID_W'(s))) begin
               new_hits = new_hits + HITS_W'(1);
            end
            if (lane_req.old_en[i] && (lane_req.old_srv[i] == SERVER_ID_W'(s))) begin
               old_hits = old_hits + HITS_W'(1);
            end
         end
         // load + new - old > limit, rearranged to stay unsigned
         up_sum       = (LOAD_W+2)'(load_ff) + (LOAD_W+2)'(new_hits);
         bound        = (LOAD_W+2)'(limit) + (LOAD_W+2)'(old_hits);
         lane_violate = ((new_hits != '0) || (old_hits != '0)) && (up_sum > bound);
         // drop the old job first, floor at zero, then add the new one, cap at max
         dec_load = (load_ff > LOAD_W'(old_hits)) ? (load_ff - LOAD_W'(old_hits)) : '0;
         inc_sum  = (LOAD_W+1)'(dec_load) + (LOAD_W+1)'(new_hits);
         load_in  = load_ff;
         if (lane_req.commit) begin
            load_in = inc_sum[LOAD_W] ? '1 : inc_sum[LOAD_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            load_ff <= '0;
         end else begin
            load_ff <= load_in;
         end
      end

      assign violate[s]  = lane_violate;
      assign busy_vec[s] = (load_ff >= limit);
   end

   assign lane_rsp.fits = ~|violate;
   assign lane_rsp.busy = busy_vec[lane_req.query_srv];

endmodule
